### src/eld_pkg.sv
// shared types, constants and fixed-point helpers for the exact longitudinal drift block
package eld_pkg;

    // working format: signed 64 bit, 44 fraction bits
    localparam int W_FRAC = 44;
    localparam logic signed [63:0] W_ONE     = 64'sh0000_1000_0000_0000;
    localparam logic signed [63:0] W_NEG_ONE = 64'shFFFF_F000_0000_0000;
    localparam logic signed [63:0] W_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] W_MIN     = 64'sh8000_0000_0000_0000;

    // number of compaction terms above the linear one that are evaluated
    localparam int HIGHER_ORDERS = 4;
    localparam int NUM_COEF_HIGH = 4;

    // quotient bit stages of the divider and root bit stages of the square root
    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = 54;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_SLIP_PERIOD = 3'd0,
        CFG_COEF_LIN    = 3'd1,
        CFG_COEF_O2     = 3'd2,
        CFG_COEF_O3     = 3'd3,
        CFG_COEF_O4     = 3'd4,
        CFG_COEF_O5     = 3'd5,
        CFG_BETA        = 3'd6,
        CFG_ENERGY      = 3'd7
    } t_cfg_idx;

    // input word
    typedef struct packed {
        logic signed [63:0] time_offset;
        logic signed [47:0] energy_offset;
        logic               end_of_bunch;
    } t_in;

    // result word
    typedef struct packed {
        logic signed [63:0] new_time_offset;
        logic               bunch_done;
        logic               saturated;
    } t_out;

    // per-particle context carried along the pipeline
    typedef struct packed {
        logic               valid;
        logic               eob;
        logic               flag;
        logic signed [63:0] dt;
        logic signed [63:0] x;
        logic signed [63:0] s;
        logic signed [63:0] delta;
        logic signed [63:0] poly;
        logic signed [63:0] pw;
    } t_ctx;

    // divider operands: magnitudes, result sign and special cases
    typedef struct packed {
        logic [127:0] num;
        logic [63:0]  den;
        logic         neg;
        logic         num_zero;
        logic         den_zero;
    } t_div_op;

    // saturated value with its clip flag
    typedef struct packed {
        logic               ovf;
        logic signed [63:0] val;
    } t_sat;

    // magnitude of a signed word, most negative value maps to 2^63
    function automatic logic [63:0] f_mag(input logic signed [63:0] v);
        logic [63:0] u;
        u = v;
        return u[63] ? (~u + 64'd1) : u;
    endfunction

    // saturating signed add
    function automatic t_sat f_add_sat(input logic signed [63:0] a,
                                       input logic signed [63:0] b);
        logic signed [64:0] sum;
        t_sat r;
        sum = {a[63], a} + {b[63], b};
        if (sum[64] != sum[63]) begin
            r.ovf = 1'b1;
            r.val = sum[64] ? W_MIN : W_MAX;
        end else begin
            r.ovf = 1'b0;
            r.val = sum[63:0];
        end
        return r;
    endfunction

    // magnitude plus sign to signed word, clipping at the range limit
    function automatic t_sat f_sat_neg(input logic [63:0] m, input logic big,
                                       input logic neg);
        logic [63:0] limit;
        logic [63:0] v;
        t_sat r;
        limit = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        v     = m;
        r.ovf = 1'b0;
        if (big || (m > limit)) begin
            r.ovf = 1'b1;
            v     = limit;
        end
        r.val = neg ? (~v + 64'd1) : v;
        return r;
    endfunction

endpackage

### src/exact_longitudinal_drift_top.sv
// top level: configuration registers and the full one-turn drift pipeline
// data path: three dividers of 64 quotient bit stages, a square root of 54 root bit stages
//   and the chain of 5-stage multipliers, ending in a registered result word and strobe
// throughput: one word per cycle, busy stays low since nothing downstream can stall
// reset: synchronous active low, clears pipeline valid bits and loads register defaults
module exact_longitudinal_drift_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  eld_pkg::t_in      i_in,
    output logic              o_strobe,
    output eld_pkg::t_out     o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  eld_pkg::t_cfg_idx i_cfg_index,
    input  logic [47:0]       i_cfg_data
);
    import eld_pkg::*;

    // configuration
    logic [47:0]        r_slip_period;
    logic signed [47:0] r_coef_lin;
    logic signed [47:0] r_coef_hi [NUM_COEF_HIGH];
    logic [31:0]        r_beta;
    logic [47:0]        r_energy;
    logic [43:0]        r_b2;
    logic [63:0]        w_beta_sq;

    // pipeline
    t_ctx    r_c0, n_c0, r_c1, n_c1, r_c2, n_c2, r_c3, r_c4, n_c4, r_c5, n_c5;
    t_ctx    r_c6, n_c6, r_c7, n_c7, r_c8, r_c9, n_c9;
    t_div_op r_d1, n_d1, r_d2, n_d2, r_d3, n_d3;
    t_ctx    w_c1, w_c2, w_c4, w_c5, w_c6a, w_c6b, w_c8, w_c9, w_c10;
    t_ctx    w_ord [0:HIGHER_ORDERS];
    logic signed [63:0] w_x, w_xx, w_q, w_ad, w_dd, w_num, w_ratio, w_chg;
    logic [63:0]        w_root;
    logic [47:0]        w_de_mag;
    t_sat    n_s1, n_s2, n_s4, n_s6, n_s7, n_s9, n_s10;
    logic    r_strobe;
    t_out    r_result;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slip_period <= '0;
            r_coef_lin    <= '0;
            for (int k = 0; k < NUM_COEF_HIGH; k++) r_coef_hi[k] <= '0;
            r_beta        <= 32'hFFFF_FFFF;
            r_energy      <= 48'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SLIP_PERIOD: r_slip_period <= i_cfg_data;
                CFG_COEF_LIN:    r_coef_lin    <= i_cfg_data;
                CFG_COEF_O2:     r_coef_hi[0]  <= i_cfg_data;
                CFG_COEF_O3:     r_coef_hi[1]  <= i_cfg_data;
                CFG_COEF_O4:     r_coef_hi[2]  <= i_cfg_data;
                CFG_COEF_O5:     r_coef_hi[3]  <= i_cfg_data;
                CFG_BETA:        r_beta        <= i_cfg_data[31:0];
                CFG_ENERGY:      r_energy      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // beta squared in working format
    assign w_beta_sq = r_beta * r_beta;

    always_ff @(posedge i_clk) begin
        r_b2 <= w_beta_sq[63:20];
    end

    // accept word, prepare x = dE / E
    always_comb begin
        n_c0       = '0;
        n_c0.valid = start;
        n_c0.eob   = i_in.end_of_bunch;
        n_c0.dt    = i_in.time_offset;
        w_de_mag   = i_in.energy_offset[47] ? (~i_in.energy_offset + 48'd1)
                                            : i_in.energy_offset;
        n_d1.num      = {52'd0, w_de_mag, 28'd0};
        n_d1.den      = {16'd0, r_energy};
        n_d1.neg      = i_in.energy_offset[47];
        n_d1.num_zero = (i_in.energy_offset == 48'sd0);
        n_d1.den_zero = (r_energy == 48'd0);
    end

    always_ff @(posedge i_clk) begin
        r_c0 <= n_c0;
        r_d1 <= n_d1;
        if (!i_rst_n) r_c0.valid <= 1'b0;
    end

    eld_div u_div_x (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctx (r_c0), .i_op (r_d1),
        .o_ctx (w_c1), .o_q (w_x)
    );

    // keep x, form 2x
    always_comb begin
        n_s1      = f_add_sat(w_x, w_x);
        n_c1      = w_c1;
        n_c1.x    = w_x;
        n_c1.pw   = n_s1.val;
        n_c1.flag = w_c1.flag | n_s1.ovf;
    end

    always_ff @(posedge i_clk) begin
        r_c1 <= n_c1;
        if (!i_rst_n) r_c1.valid <= 1'b0;
    end

    eld_mul u_mul_xx (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctx (r_c1), .i_a (r_c1.x), .i_b (r_c1.x),
        .o_ctx (w_c2), .o_p (w_xx)
    );

    // t = x*x + 2x
    always_comb begin
        n_s2      = f_add_sat(w_xx, w_c2.pw);
        n_c2      = w_c2;
        n_c2.pw   = n_s2.val;
        n_c2.flag = w_c2.flag | n_s2.ovf;
    end

    always_ff @(posedge i_clk) begin
        r_c2 <= n_c2;
        if (!i_rst_n) r_c2.valid <= 1'b0;
    end

    // divider operands for t / beta^2
    always_comb begin
        n_d2.num      = {20'd0, f_mag(r_c2.pw), 44'd0};
        n_d2.den      = {20'd0, r_b2};
        n_d2.neg      = r_c2.pw[63];
        n_d2.num_zero = (r_c2.pw == 64'sd0);
        n_d2.den_zero = (r_b2 == 44'd0);
    end

    always_ff @(posedge i_clk) begin
        r_c3 <= r_c2;
        r_d2 <= n_d2;
        if (!i_rst_n) r_c3.valid <= 1'b0;
    end

    eld_div u_div_q (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctx (r_c3), .i_op (r_d2),
        .o_ctx (w_c4), .o_q (w_q)
    );

    // radicand 1 + q, clamped at zero
    always_comb begin
        n_s4      = f_add_sat(W_ONE, w_q);
        n_c4      = w_c4;
        n_c4.flag = w_c4.flag | n_s4.ovf;
        if (n_s4.val[63]) begin
            n_c4.s    = '0;
            n_c4.flag = 1'b1;
        end else begin
            n_c4.s = n_s4.val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c4 <= n_c4;
        if (!i_rst_n) r_c4.valid <= 1'b0;
    end

    eld_sqrt u_sqrt (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctx (r_c4), .i_rad (r_c4.s),
        .o_ctx (w_c5), .o_root (w_root)
    );

    // s and delta = s - 1
    always_comb begin
        n_c5       = w_c5;
        n_c5.s     = w_root;
        n_c5.delta = w_root - W_ONE;
    end

    always_ff @(posedge i_clk) begin
        r_c5 <= n_c5;
        if (!i_rst_n) r_c5.valid <= 1'b0;
    end

    eld_mul u_mul_lin (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctx (r_c5),
        .i_a ({{16{r_coef_lin[47]}}, r_coef_lin}), .i_b (r_c5.delta),
        .o_ctx (w_c6a), .o_p (w_ad)
    );

    eld_mul u_mul_sq (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctx (r_c5),
        .i_a (r_c5.delta), .i_b (r_c5.delta),
        .o_ctx (w_c6b), .o_p (w_dd)
    );

    // poly = 1 + a0*delta, power = delta^2
    always_comb begin
        n_s6      = f_add_sat(W_ONE, w_ad);
        n_c6      = w_c6a;
        n_c6.poly = n_s6.val;
        n_c6.pw   = w_dd;
        n_c6.flag = w_c6a.flag | w_c6b.flag | n_s6.ovf;
    end

    always_ff @(posedge i_clk) begin
        r_c6 <= n_c6;
        if (!i_rst_n) r_c6.valid <= 1'b0;
    end

    // higher-order terms
    assign w_ord[0] = r_c6;

    for (genvar k = 0; k < HIGHER_ORDERS; k++) begin : g_ord
        eld_order u_ord (
            .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctx (w_ord[k]),
            .i_coef (r_coef_hi[k]), .o_ctx (w_ord[k+1])
        );
    end

    // 1 + x
    always_comb begin
        n_s7      = f_add_sat(W_ONE, w_ord[HIGHER_ORDERS].x);
        n_c7      = w_ord[HIGHER_ORDERS];
        n_c7.pw   = n_s7.val;
        n_c7.flag = w_ord[HIGHER_ORDERS].flag | n_s7.ovf;
    end

    always_ff @(posedge i_clk) begin
        r_c7 <= n_c7;
        if (!i_rst_n) r_c7.valid <= 1'b0;
    end

    eld_mul u_mul_num (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctx (r_c7),
        .i_a (r_c7.poly), .i_b (r_c7.pw),
        .o_ctx (w_c8), .o_p (w_num)
    );

    // divider operands for num / s
    always_comb begin
        n_d3.num      = {20'd0, f_mag(w_num), 44'd0};
        n_d3.den      = w_c8.s;
        n_d3.neg      = w_num[63];
        n_d3.num_zero = (w_num == 64'sd0);
        n_d3.den_zero = (w_c8.s == 64'sd0);
    end

    always_ff @(posedge i_clk) begin
        r_c8 <= w_c8;
        r_d3 <= n_d3;
        if (!i_rst_n) r_c8.valid <= 1'b0;
    end

    eld_div u_div_ratio (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctx (r_c8), .i_op (r_d3),
        .o_ctx (w_c9), .o_q (w_ratio)
    );

    // f = ratio - 1
    always_comb begin
        n_s9      = f_add_sat(w_ratio, W_NEG_ONE);
        n_c9      = w_c9;
        n_c9.pw   = n_s9.val;
        n_c9.flag = w_c9.flag | n_s9.ovf;
    end

    always_ff @(posedge i_clk) begin
        r_c9 <= n_c9;
        if (!i_rst_n) r_c9.valid <= 1'b0;
    end

    eld_mul u_mul_chg (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctx (r_c9),
        .i_a ({16'd0, r_slip_period}), .i_b (r_c9.pw),
        .o_ctx (w_c10), .o_p (w_chg)
    );

    // new time and result word
    assign n_s10 = f_add_sat(w_c10.dt, w_chg);

    always_ff @(posedge i_clk) begin
        r_result.new_time_offset <= n_s10.val;
        r_result.bunch_done      <= w_c10.eob;
        r_result.saturated       <= w_c10.flag | n_s10.ovf;
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_c10.valid;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

### src/eld_mul.sv
// pipelined saturating fixed-point multiplier built from 32x32 partial products
module eld_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  eld_pkg::t_ctx      i_ctx,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output eld_pkg::t_ctx      o_ctx,
    output logic signed [63:0] o_p
);
    import eld_pkg::*;

    t_ctx         r_ctx1, r_ctx2, r_ctx3, r_ctx4, r_ctx5;
    logic [63:0]  r_ma, r_mb;
    logic         r_neg1, r_neg2, r_neg3, r_neg4;
    logic [63:0]  r_p00, r_p01, r_p10, r_p11;
    logic [63:0]  r_p00_3, r_p11_3;
    logic [64:0]  r_mid;
    logic [83:0]  r_sh;
    logic signed [63:0] r_p;
    logic [127:0] n_full;
    t_sat         n_sat;
    t_ctx         n_ctx5;

    // stage 1: magnitudes and product sign
    always_ff @(posedge i_clk) begin
        r_ctx1 <= i_ctx;
        r_ma   <= f_mag(i_a);
        r_mb   <= f_mag(i_b);
        r_neg1 <= i_a[63] ^ i_b[63];
        if (!i_rst_n) r_ctx1.valid <= 1'b0;
    end

    // stage 2: four partial products
    always_ff @(posedge i_clk) begin
        r_ctx2 <= r_ctx1;
        r_neg2 <= r_neg1;
        r_p00  <= r_ma[31:0]  * r_mb[31:0];
        r_p01  <= r_ma[31:0]  * r_mb[63:32];
        r_p10  <= r_ma[63:32] * r_mb[31:0];
        r_p11  <= r_ma[63:32] * r_mb[63:32];
        if (!i_rst_n) r_ctx2.valid <= 1'b0;
    end

    // stage 3: middle terms
    always_ff @(posedge i_clk) begin
        r_ctx3  <= r_ctx2;
        r_neg3  <= r_neg2;
        r_mid   <= {1'b0, r_p01} + {1'b0, r_p10};
        r_p00_3 <= r_p00;
        r_p11_3 <= r_p11;
        if (!i_rst_n) r_ctx3.valid <= 1'b0;
    end

    // stage 4: full product, drop fraction bits
    assign n_full = {r_p11_3, 64'd0} + {31'd0, r_mid, 32'd0} + {64'd0, r_p00_3};

    always_ff @(posedge i_clk) begin
        r_ctx4 <= r_ctx3;
        r_neg4 <= r_neg3;
        r_sh   <= n_full[127:44];
        if (!i_rst_n) r_ctx4.valid <= 1'b0;
    end

    // stage 5: clip and apply sign
    always_comb begin
        n_sat       = f_sat_neg(r_sh[63:0], |r_sh[83:64], r_neg4);
        n_ctx5      = r_ctx4;
        n_ctx5.flag = r_ctx4.flag | n_sat.ovf;
    end

    always_ff @(posedge i_clk) begin
        r_ctx5 <= n_ctx5;
        r_p    <= n_sat.val;
        if (!i_rst_n) r_ctx5.valid <= 1'b0;
    end

    assign o_ctx = r_ctx5;
    assign o_p   = r_p;

endmodule

### src/eld_div.sv
// pipelined restoring divider, one quotient bit per stage, saturating signed result
module eld_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  eld_pkg::t_ctx      i_ctx,
    input  eld_pkg::t_div_op   i_op,
    output eld_pkg::t_ctx      o_ctx,
    output logic signed [63:0] o_q
);
    import eld_pkg::*;

    typedef struct packed {
        t_ctx        ctx;
        logic [63:0] den;
        logic [63:0] rem;
        logic [63:0] low;
        logic [63:0] quo;
        logic        big;
        logic        neg;
        logic        num_zero;
        logic        den_zero;
    } t_dstage;

    t_dstage r_st [0:DIV_STEPS];
    t_dstage n_st0;
    t_dstage n_st [1:DIV_STEPS];
    t_ctx    r_ctx;
    t_ctx    n_ctx;
    logic signed [63:0] r_q;
    logic signed [63:0] n_q;
    t_sat    n_sat;

    // one long-division step
    function automatic t_dstage f_step(input t_dstage s);
        logic [64:0] rr;
        logic [64:0] dd;
        logic [64:0] diff;
        t_dstage nx;
        rr   = {s.rem, s.low[63]};
        dd   = {1'b0, s.den};
        diff = rr - dd;
        nx   = s;
        if (rr >= dd) begin
            nx.rem = diff[63:0];
            nx.quo = {s.quo[62:0], 1'b1};
        end else begin
            nx.rem = rr[63:0];
            nx.quo = {s.quo[62:0], 1'b0};
        end
        nx.low = {s.low[62:0], 1'b0};
        return nx;
    endfunction

    // entry: quotient at or above 2^64 is flagged up front
    always_comb begin
        n_st0.ctx      = i_ctx;
        n_st0.den      = i_op.den;
        n_st0.rem      = i_op.num[127:64];
        n_st0.low      = i_op.num[63:0];
        n_st0.quo      = '0;
        n_st0.big      = (i_op.num[127:64] >= i_op.den);
        n_st0.neg      = i_op.neg;
        n_st0.num_zero = i_op.num_zero;
        n_st0.den_zero = i_op.den_zero;
    end

    // quotient bit stages
    always_comb begin
        for (int i = 1; i <= DIV_STEPS; i++) begin
            n_st[i] = f_step(r_st[i-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_st[0] <= n_st0;
        for (int i = 1; i <= DIV_STEPS; i++) begin
            r_st[i] <= n_st[i];
        end
        if (!i_rst_n) begin
            for (int i = 0; i <= DIV_STEPS; i++) begin
                r_st[i].ctx.valid <= 1'b0;
            end
        end
    end

    // result: zero numerator, zero divisor, else clipped quotient
    always_comb begin
        n_sat = f_sat_neg(r_st[DIV_STEPS].quo, r_st[DIV_STEPS].big, r_st[DIV_STEPS].neg);
        n_ctx = r_st[DIV_STEPS].ctx;
        priority if (r_st[DIV_STEPS].num_zero) begin
            n_q = '0;
        end else if (r_st[DIV_STEPS].den_zero) begin
            n_q        = r_st[DIV_STEPS].neg ? W_MIN : W_MAX;
            n_ctx.flag = 1'b1;
        end else begin
            n_q        = n_sat.val;
            n_ctx.flag = r_st[DIV_STEPS].ctx.flag | n_sat.ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctx <= n_ctx;
        r_q   <= n_q;
        if (!i_rst_n) r_ctx.valid <= 1'b0;
    end

    assign o_ctx = r_ctx;
    assign o_q   = r_q;

endmodule

### src/eld_sqrt.sv
// pipelined digit-by-digit integer square root of rad shifted up by the fraction width
module eld_sqrt (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  eld_pkg::t_ctx i_ctx,
    input  logic [63:0]   i_rad,
    output eld_pkg::t_ctx o_ctx,
    output logic [63:0]   o_root
);
    import eld_pkg::*;

    typedef struct packed {
        t_ctx         ctx;
        logic [56:0]  rem;
        logic [53:0]  root;
        logic [107:0] bits;
    } t_sstage;

    t_sstage r_st [0:SQRT_STEPS];
    t_sstage n_st0;
    t_sstage n_st [1:SQRT_STEPS];

    // one root bit per step
    function automatic t_sstage f_step(input t_sstage s);
        logic [56:0] rr;
        logic [56:0] trial;
        t_sstage nx;
        rr    = {s.rem[54:0], s.bits[107:106]};
        trial = {1'b0, s.root, 2'b01};
        nx    = s;
        if (rr >= trial) begin
            nx.rem  = rr - trial;
            nx.root = {s.root[52:0], 1'b1};
        end else begin
            nx.rem  = rr;
            nx.root = {s.root[52:0], 1'b0};
        end
        nx.bits = {s.bits[105:0], 2'b00};
        return nx;
    endfunction

    // entry
    always_comb begin
        n_st0.ctx  = i_ctx;
        n_st0.rem  = '0;
        n_st0.root = '0;
        n_st0.bits = {i_rad, 44'd0};
    end

    always_comb begin
        for (int i = 1; i <= SQRT_STEPS; i++) begin
            n_st[i] = f_step(r_st[i-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_st[0] <= n_st0;
        for (int i = 1; i <= SQRT_STEPS; i++) begin
            r_st[i] <= n_st[i];
        end
        if (!i_rst_n) begin
            for (int i = 0; i <= SQRT_STEPS; i++) begin
                r_st[i].ctx.valid <= 1'b0;
            end
        end
    end

    assign o_ctx  = r_st[SQRT_STEPS].ctx;
    assign o_root = {10'd0, r_st[SQRT_STEPS].root};

endmodule

### src/eld_order.sv
// one higher-order compaction term: coefficient times power, next power, accumulate
module eld_order (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  eld_pkg::t_ctx      i_ctx,
    input  logic signed [47:0] i_coef,
    output eld_pkg::t_ctx      o_ctx
);
    import eld_pkg::*;

    t_ctx w_ctx_a, w_ctx_b;
    logic signed [63:0] w_cp, w_pd;
    t_ctx r_ctx, n_ctx;
    t_sat n_sum;

    // coefficient times current power
    eld_mul u_cp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctx   (i_ctx),
        .i_a     ({{16{i_coef[47]}}, i_coef}),
        .i_b     (i_ctx.pw),
        .o_ctx   (w_ctx_a),
        .o_p     (w_cp)
    );

    // next power of delta
    eld_mul u_pd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctx   (i_ctx),
        .i_a     (i_ctx.pw),
        .i_b     (i_ctx.delta),
        .o_ctx   (w_ctx_b),
        .o_p     (w_pd)
    );

    // accumulate into the polynomial
    always_comb begin
        n_sum      = f_add_sat(w_ctx_a.poly, w_cp);
        n_ctx      = w_ctx_a;
        n_ctx.poly = n_sum.val;
        n_ctx.pw   = w_pd;
        n_ctx.flag = w_ctx_a.flag | w_ctx_b.flag | n_sum.ovf;
    end

    always_ff @(posedge i_clk) begin
        r_ctx <= n_ctx;
        if (!i_rst_n) r_ctx.valid <= 1'b0;
    end

    assign o_ctx = r_ctx;

endmodule
